[hw/rtl/pidfd_pkg.sv]
// ----------------------------------------------------------------------------
// pidfd_pkg
// Types and constants for the filtered-derivative PID step: payload structs,
// register indexes and the reset values of the coefficient registers.
// ----------------------------------------------------------------------------
package pidfd_pkg;

    // Data word width (signed fixed point)
    localparam int DW = 32;

    // Saturation limits of the data word
    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    // Register reset values, Q16.16
    localparam logic signed [DW-1:0] KP_RST         = 32'sd131072;
    localparam logic signed [DW-1:0] KI_HALF_T_RST  = 32'sd164;
    localparam logic signed [DW-1:0] DERIV_GAIN_RST = 32'sd655360;
    localparam logic signed [DW-1:0] DERIV_POLE_RST = 32'sd39322;
    localparam logic signed [DW-1:0] OUT_MIN_RST    = -32'sd65536000;
    localparam logic signed [DW-1:0] OUT_MAX_RST    = 32'sd65536000;
    localparam logic signed [DW-1:0] INT_MIN_RST    = -32'sd327680;
    localparam logic signed [DW-1:0] INT_MAX_RST    = 32'sd327680;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP         = 3'd0,
        CFG_KI_HALF_T  = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_DERIV_POLE = 3'd3,
        CFG_OUT_MIN    = 3'd4,
        CFG_OUT_MAX    = 3'd5,
        CFG_INT_MIN    = 3'd6,
        CFG_INT_MAX    = 3'd7
    } t_cfg_idx;

    // Input beat
    typedef struct packed {
        logic signed [DW-1:0] target_value;
        logic signed [DW-1:0] measured_value;
    } t_pid_in;

    // Result beat
    typedef struct packed {
        logic signed [DW-1:0] control_out;
        logic                 out_clamped;
    } t_pid_out;

endpackage

[hw/rtl/pid_controller_filtered_derivative.sv]
// ----------------------------------------------------------------------------
// pid_controller_filtered_derivative
// Discrete PID step in signed fixed point with a clamped trapezoidal
// integrator, a band-limited derivative on the measurement and a clamped,
// flagged output.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle and returns one result beat
// for each, in order. An accepted beat is held in the stage 1 registers and
// moves on into the result register once the result stage is empty or is
// being drained. The first stage forms the error terms and the
// proportional product; the second stage closes the integrator and the
// derivative filter recurrences combinationally, which is what sets the
// rate of one beat per cycle. Back-pressure on the output stalls both stages.
// Coefficient registers are written through the configuration channel,
// which is always ready; write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module pid_controller_filtered_derivative
    import pidfd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_pid_in              i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_pid_out             o_out_data,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DW-1:0]        i_cfg_data
);

    localparam int PW = 2 * DW;
    localparam int QW = PW - FRAC_BITS;

    // ------------------------------------------------------------------
    // Arithmetic helpers
    // ------------------------------------------------------------------

    // Saturating add
    function automatic logic signed [DW-1:0] sat_add(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b
    );
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? SMIN : SMAX;
        end
        return s[DW-1:0];
    endfunction

    // Saturating subtract
    function automatic logic signed [DW-1:0] sat_sub(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b
    );
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? SMIN : SMAX;
        end
        return s[DW-1:0];
    endfunction

    // Fixed-point product, floored, saturated
    function automatic logic signed [DW-1:0] fmul(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b
    );
        logic signed [PW-1:0] prod;
        logic signed [QW-1:0] q;
        prod = a * b;
        q    = prod[PW-1:FRAC_BITS];
        if (!((&q[QW-1:DW-1]) || !(|q[QW-1:DW-1]))) begin
            return q[QW-1] ? SMIN : SMAX;
        end
        return q[DW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_kp, r_ki_half_t, r_deriv_gain, r_deriv_pole;
    logic signed [DW-1:0] r_out_min, r_out_max, r_int_min, r_int_max;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= KP_RST;
            r_ki_half_t  <= KI_HALF_T_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_deriv_pole <= DERIV_POLE_RST;
            r_out_min    <= OUT_MIN_RST;
            r_out_max    <= OUT_MAX_RST;
            r_int_min    <= INT_MIN_RST;
            r_int_max    <= INT_MAX_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KP:         r_kp         <= i_cfg_data;
                CFG_KI_HALF_T:  r_ki_half_t  <= i_cfg_data;
                CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                CFG_DERIV_POLE: r_deriv_pole <= i_cfg_data;
                CFG_OUT_MIN:    r_out_min    <= i_cfg_data;
                CFG_OUT_MAX:    r_out_max    <= i_cfg_data;
                CFG_INT_MIN:    r_int_min    <= i_cfg_data;
                CFG_INT_MAX:    r_int_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic     r_in_valid;
    logic     r_out_valid;
    t_pid_out r_out;
    logic     in_accept;
    logic     advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // fill or drain the input stage
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // fill or drain the result stage
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: error terms, measurement step, proportional product
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_prev_error, r_prev_measure;
    logic signed [DW-1:0] r_s1_p, r_s1_esum, r_s1_dmeas;
    logic signed [DW-1:0] n_error;

    assign n_error = sat_sub(i_in_data.target_value, i_in_data.measured_value);

    // history of accepted beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error   <= '0;
            r_prev_measure <= '0;
        end else if (in_accept) begin
            r_prev_error   <= n_error;
            r_prev_measure <= i_in_data.measured_value;
        end
    end

    // capture stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_p     <= fmul(r_kp, n_error);
            r_s1_esum  <= sat_add(n_error, r_prev_error);
            r_s1_dmeas <= sat_sub(i_in_data.measured_value, r_prev_measure);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: integrator, derivative filter, output sum and clamp
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_integrator, r_deriv_state;
    logic signed [DW-1:0] int_sum, n_integrator, n_deriv_state;
    logic signed [DW-1:0] u_sum;
    t_pid_out             n_out;

    always_comb begin
        // trapezoidal integrator with clamp, upper limit tested first
        int_sum = sat_add(r_integrator, fmul(r_ki_half_t, r_s1_esum));
        if (int_sum > r_int_max) begin
            n_integrator = r_int_max;
        end else if (int_sum < r_int_min) begin
            n_integrator = r_int_min;
        end else begin
            n_integrator = int_sum;
        end

        // band-limited derivative on the measurement
        n_deriv_state = sat_sub(fmul(r_deriv_pole, r_deriv_state),
                                fmul(r_deriv_gain, r_s1_dmeas));

        // drive value with output clamp and flag
        u_sum = sat_add(sat_add(r_s1_p, n_integrator), n_deriv_state);
        if (u_sum > r_out_max) begin
            n_out.control_out = r_out_max;
            n_out.out_clamped = 1'b1;
        end else if (u_sum < r_out_min) begin
            n_out.control_out = r_out_min;
            n_out.out_clamped = 1'b1;
        end else begin
            n_out.control_out = u_sum;
            n_out.out_clamped = 1'b0;
        end
    end

    // advance controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integrator  <= '0;
            r_deriv_state <= '0;
        end else if (advance) begin
            r_integrator  <= n_integrator;
            r_deriv_state <= n_deriv_state;
        end
    end

    // capture result beat
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // an empty result stage never blocks the input
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result stage");

    // a held input beat stays until it moves on
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input stage beat lost");

    // integrator respects ordered limits after an update
    a_int_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_int_min <= r_int_max)) |=>
        (r_integrator <= $past(r_int_max) && r_integrator >= $past(r_int_min)))
        else $error("integrator outside its limits");

    // an unflagged result lies within the output limits
    a_out_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.out_clamped ||
                     (r_out.control_out <= $past(r_out_max) &&
                      r_out.control_out >= $past(r_out_min))))
        else $error("unflagged result outside output limits");

endmodule
